@@ src/bitmap_set_with_select_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Bitmap set assertion macros
// Shared concurrent assertion shorthands, clocked on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef BITMAP_SET_WITH_SELECT_UNIT_MACROS_SVH
`define BITMAP_SET_WITH_SELECT_UNIT_MACROS_SVH

// ante must be followed by cons in the same cycle
`define BMSET_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// cond must never hold
`define BMSET_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

@@ src/bmset_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap set package
// Sizes, operation and status codes, sequencer states and word helpers.
// ----------------------------------------------------------------------------
package bmset_pkg;

	localparam int BITMAP_WORDS = 4096;
	localparam int WORD_W       = 16;
	localparam int BIT_W        = 4;
	localparam int WADDR_W      = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
	localparam int CAPACITY     = BITMAP_WORDS * WORD_W;
	// position register: holds -1 (all ones) up to CAPACITY
	localparam int CPOS_W       = $clog2(CAPACITY) + 1;
	localparam int COUNT_W      = 17;
	localparam int ENTRY_W      = 16;
	localparam int ORD_W        = 16;
	localparam int OP_W         = 3;
	localparam int STAT_W       = 2;
	localparam int CNT_POP_W    = BIT_W + 1;
	localparam int S_TDATA_W    = 32;
	localparam int M_TDATA_W    = 40;

	localparam logic [WORD_W-1:0] WORD_ALL = 16'hFFFF;
	localparam logic [BIT_W-1:0]  BIT_LAST = 4'd15;

	localparam logic [OP_W-1:0] OP_ENTER    = 3'd0;
	localparam logic [OP_W-1:0] OP_REMOVE   = 3'd1;
	localparam logic [OP_W-1:0] OP_CONTAINS = 3'd2;
	localparam logic [OP_W-1:0] OP_GET_NTH  = 3'd3;
	localparam logic [OP_W-1:0] OP_NEXT     = 3'd4;

	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FALSE = 2'd1;
	localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;
	localparam logic [STAT_W-1:0] STAT_NONE  = 2'd3;

	typedef enum logic [4:0] {
		ST_CLEAR  = 5'b00001,
		ST_IDLE   = 5'b00010,
		ST_MODIFY = 5'b00100,
		ST_SCAN   = 5'b01000,
		ST_SELECT = 5'b10000
	} state_t;

	function automatic logic [CNT_POP_W-1:0] pop_word(input logic [WORD_W-1:0] v);
		logic [CNT_POP_W-1:0] c;
		c = '0;
		for (int i = 0; i < WORD_W; i++) begin
			c = c + CNT_POP_W'(v[i]);
		end
		return c;
	endfunction

	// lowest set bit, BIT_LAST when the word is empty
	function automatic logic [BIT_W-1:0] low_bit(input logic [WORD_W-1:0] v);
		logic [BIT_W-1:0] r;
		r = BIT_LAST;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (v[i]) begin
				r = BIT_W'(i);
			end
		end
		return r;
	endfunction

endpackage

@@ src/bmset_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap set RAM
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bmset_ram #(
	parameter int DATA_W = 16,
	parameter int DEPTH  = 4096,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

@@ src/bitmap_set_with_select_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap set with rank/select
// Entry set held as 16-bit bitmap words in RAM with a member count and an
// iterator cursor; enter, remove, contains, get nth member and next member.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Signals                   Content
// s_       in   tvalid tready tdata tuser one operation: tuser = operation,
//                                         tdata = entry_number, ordinal
// m_       out  tvalid tready tdata tuser one result: tuser = status,
//                                         tdata = found_entry, member_count
//
// Sequence: enter, remove, contains read the RAM word, then modify and write. Next
// and a continuing get nth scan on from the cursor word by word; a fresh get nth
// scans from word zero, then drops set bits to pick the wanted one. A rank past
// the count, an exhausted cursor, out-of-range entries, unused codes skip the RAM.
// Reset: a clearing pass writes all 4096 words after arst_n with s_tready low.
// Stalls: one transaction at a time; s_tready waits for the output slot to drain.
// ----------------------------------------------------------------------------
`include "bitmap_set_with_select_unit_macros.svh"

module bitmap_set_with_select_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// [15:0] entry_number, [31:16] ordinal
	input  logic [bmset_pkg::S_TDATA_W-1:0]    s_tdata,
	// [2:0] operation
	input  logic [bmset_pkg::OP_W-1:0]         s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// [15:0] found_entry, [32:16] member_count, [39:33] zero
	output logic [bmset_pkg::M_TDATA_W-1:0]    m_tdata,
	// [1:0] status
	output logic [bmset_pkg::STAT_W-1:0]       m_tuser
);

	localparam int WADDR_W = bmset_pkg::WADDR_W;
	localparam int WORD_W  = bmset_pkg::WORD_W;
	localparam int BIT_W   = bmset_pkg::BIT_W;
	localparam int COUNT_W = bmset_pkg::COUNT_W;
	localparam int CPOS_W  = bmset_pkg::CPOS_W;
	localparam int ENTRY_W = bmset_pkg::ENTRY_W;
	localparam int ORD_W   = bmset_pkg::ORD_W;
	localparam int STAT_W  = bmset_pkg::STAT_W;
	localparam int OP_W    = bmset_pkg::OP_W;
	localparam logic [WADDR_W-1:0] LAST_WORD = WADDR_W'(bmset_pkg::BITMAP_WORDS - 1);

	// ---------------------------------------------------------------- state
	bmset_pkg::state_t state_q, state_d;

	logic [WADDR_W-1:0] clr_q, clr_d;           // clearing pass address
	logic [WADDR_W-1:0] iss_q, iss_d;           // scan: word being read
	logic [WADDR_W-1:0] ev_q, ev_d;             // scan: word whose data is back
	logic               dvalid_q, dvalid_d;     // rd_data holds word ev_q
	logic               first_q, first_d;       // first word of a scan
	logic               mode_nth_q, mode_nth_d; // rank scan vs. cursor scan
	logic [BIT_W-1:0]   shift_q, shift_d;       // start bit in first word
	logic [COUNT_W-1:0] nrem_q, nrem_d;         // rank left to skip
	logic [ORD_W-1:0]   req_n_q, req_n_d;       // requested rank
	logic [WORD_W-1:0]  sel_word_q, sel_word_d;
	logic [BIT_W-1:0]   sel_n_q, sel_n_d;
	logic [WADDR_W-1:0] sel_widx_q, sel_widx_d;
	logic [OP_W-1:0]    mod_op_q, mod_op_d;
	logic [WADDR_W-1:0] mod_addr_q, mod_addr_d;
	logic [BIT_W-1:0]   mod_bit_q, mod_bit_d;

	logic [COUNT_W-1:0] member_total_q, member_total_d;
	logic [COUNT_W-1:0] cur_rank_q, cur_rank_d;  // all ones: no cursor (reset or exhausted)
	logic [CPOS_W-1:0]  cur_pos_q, cur_pos_d;    // all ones: before entry 0

	logic               m_tvalid_q, m_tvalid_d;
	logic [STAT_W-1:0]  m_status_q, m_status_d;
	logic [ENTRY_W-1:0] m_found_q, m_found_d;
	logic [COUNT_W-1:0] m_count_q, m_count_d;

	// ------------------------------------------------------------------ RAM
	logic               ram_we;
	logic [WADDR_W-1:0] ram_wr_addr;
	logic [WORD_W-1:0]  ram_wr_data;
	logic [WADDR_W-1:0] ram_rd_addr;
	logic [WORD_W-1:0]  ram_rd_data;

	bmset_ram #(
		.DATA_W (WORD_W),
		.DEPTH  (bmset_pkg::BITMAP_WORDS)
	) u_bitmap (
		.clk     (clk),
		.we      (ram_we),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	// -------------------------------------------------------- input decode
	logic                 s_accept;
	logic [ENTRY_W-1:0]   in_entry;
	logic [ORD_W-1:0]     in_ord;
	logic [OP_W-1:0]      in_op;
	logic                 entry_oor;
	logic [WADDR_W-1:0]   entry_word;

	assign s_tready   = (state_q == bmset_pkg::ST_IDLE) && (!m_tvalid_q || m_tready);
	assign s_accept   = s_tvalid && s_tready;
	assign in_entry   = s_tdata[ENTRY_W-1:0];
	assign in_ord     = s_tdata[ENTRY_W+ORD_W-1:ENTRY_W];
	assign in_op      = s_tuser;
	assign entry_oor  = 32'(in_entry) >= 32'(bmset_pkg::CAPACITY);
	assign entry_word = WADDR_W'(in_entry >> BIT_W);

	// cursor step preparation: rank + 1 and position + 1 wrap -1 to 0
	logic [COUNT_W-1:0] rank_inc;
	logic [CPOS_W-1:0]  pos_inc;
	logic [CPOS_W-1:0]  from_word;
	logic               adv_end;
	logic               from_oor;

	assign rank_inc  = cur_rank_q + 1'b1;
	assign pos_inc   = cur_pos_q + 1'b1;
	assign from_word = pos_inc >> BIT_W;
	assign adv_end   = rank_inc >= member_total_q;
	assign from_oor  = 32'(from_word) >= 32'(bmset_pkg::BITMAP_WORDS);

	// ------------------------------------------------------ shared word unit
	// One popcount / lowest-bit / compare unit serves the scan; select has its own lowest-bit finder.
	logic [WORD_W-1:0]               scan_word;
	logic [bmset_pkg::CNT_POP_W-1:0] scan_cnt;
	logic [BIT_W-1:0]                scan_bit;
	logic [BIT_W-1:0]                sel_bit;
	logic                            scan_last;
	logic                            has_bit;

	assign scan_word = ram_rd_data & ((first_q && !mode_nth_q) ?
		(bmset_pkg::WORD_ALL << shift_q) : bmset_pkg::WORD_ALL);
	assign scan_cnt  = bmset_pkg::pop_word(scan_word);
	assign scan_bit  = bmset_pkg::low_bit(scan_word);
	assign sel_bit   = bmset_pkg::low_bit(sel_word_q);
	assign scan_last = ev_q == LAST_WORD;
	assign has_bit   = ram_rd_data[mod_bit_q];

	// ------------------------------------------------------------ sequencer
	logic               fin;
	logic [STAT_W-1:0]  fin_status;
	logic [ENTRY_W-1:0] fin_found;

	always_comb begin
		state_d        = state_q;
		clr_d          = clr_q;
		iss_d          = iss_q;
		ev_d           = ev_q;
		dvalid_d       = dvalid_q;
		first_d        = first_q;
		mode_nth_d     = mode_nth_q;
		shift_d        = shift_q;
		nrem_d         = nrem_q;
		req_n_d        = req_n_q;
		sel_word_d     = sel_word_q;
		sel_n_d        = sel_n_q;
		sel_widx_d     = sel_widx_q;
		mod_op_d       = mod_op_q;
		mod_addr_d     = mod_addr_q;
		mod_bit_d      = mod_bit_q;
		member_total_d = member_total_q;
		cur_rank_d     = cur_rank_q;
		cur_pos_d      = cur_pos_q;
		ram_we         = 1'b0;
		ram_wr_addr    = mod_addr_q;
		ram_wr_data    = ram_rd_data;
		ram_rd_addr    = (state_q == bmset_pkg::ST_SCAN) ? iss_q : entry_word;
		fin            = 1'b0;
		fin_status     = bmset_pkg::STAT_FALSE;
		fin_found      = '0;

		unique case (state_q)
			bmset_pkg::ST_CLEAR: begin
				ram_we      = 1'b1;
				ram_wr_addr = clr_q;
				ram_wr_data = '0;
				clr_d       = clr_q + 1'b1;
				if (clr_q == LAST_WORD) begin
					state_d = bmset_pkg::ST_IDLE;
				end
			end

			bmset_pkg::ST_IDLE: begin
				if (s_accept) begin
					req_n_d    = in_ord;
					mod_op_d   = in_op;
					mod_addr_d = entry_word;
					mod_bit_d  = in_entry[BIT_W-1:0];
					unique case (in_op)
						bmset_pkg::OP_ENTER, bmset_pkg::OP_REMOVE,
						bmset_pkg::OP_CONTAINS: begin
							if (entry_oor) begin
								fin        = 1'b1;
								fin_status = bmset_pkg::STAT_RANGE;
							end else begin
								// word read issued this cycle
								state_d = bmset_pkg::ST_MODIFY;
							end
						end
						bmset_pkg::OP_GET_NTH, bmset_pkg::OP_NEXT: begin
							priority if ((in_op == bmset_pkg::OP_GET_NTH) &&
								(COUNT_W'(in_ord) >= member_total_q)) begin
								fin        = 1'b1;
								fin_status = bmset_pkg::STAT_NONE;
							end else if ((in_op == bmset_pkg::OP_GET_NTH) &&
								(COUNT_W'(in_ord) != rank_inc)) begin
								// rank scan from word zero
								state_d    = bmset_pkg::ST_SCAN;
								mode_nth_d = 1'b1;
								iss_d      = '0;
								dvalid_d   = 1'b0;
								first_d    = 1'b1;
								nrem_d     = COUNT_W'(in_ord);
							end else if (adv_end || from_oor) begin
								// cursor exhausted
								cur_rank_d = '1;
								cur_pos_d  = '1;
								fin        = 1'b1;
								fin_status = bmset_pkg::STAT_NONE;
							end else begin
								// cursor scan from the bit after the cursor
								state_d    = bmset_pkg::ST_SCAN;
								mode_nth_d = 1'b0;
								iss_d      = WADDR_W'(from_word);
								shift_d    = pos_inc[BIT_W-1:0];
								dvalid_d   = 1'b0;
								first_d    = 1'b1;
							end
						end
						default: begin
							fin        = 1'b1;
							fin_status = bmset_pkg::STAT_FALSE;
						end
					endcase
				end
			end

			bmset_pkg::ST_MODIFY: begin
				state_d = bmset_pkg::ST_IDLE;
				fin     = 1'b1;
				unique case (mod_op_q)
					bmset_pkg::OP_ENTER: begin
						if (!has_bit) begin
							ram_we         = 1'b1;
							ram_wr_data    = ram_rd_data | (WORD_W'(1) << mod_bit_q);
							member_total_d = member_total_q + 1'b1;
							fin_status     = bmset_pkg::STAT_OK;
						end
					end
					bmset_pkg::OP_REMOVE: begin
						if (has_bit) begin
							ram_we         = 1'b1;
							ram_wr_data    = ram_rd_data & ~(WORD_W'(1) << mod_bit_q);
							member_total_d = member_total_q - 1'b1;
							fin_status     = bmset_pkg::STAT_OK;
						end
					end
					default: begin
						fin_status = has_bit ? bmset_pkg::STAT_OK : bmset_pkg::STAT_FALSE;
					end
				endcase
			end

			bmset_pkg::ST_SCAN: begin
				// one word read per cycle, data back in the next cycle
				iss_d    = iss_q + 1'b1;
				ev_d     = iss_q;
				dvalid_d = 1'b1;
				if (dvalid_q) begin
					first_d = 1'b0;
					if (mode_nth_q) begin
						if (nrem_q < COUNT_W'(scan_cnt)) begin
							state_d    = bmset_pkg::ST_SELECT;
							sel_word_d = scan_word;
							sel_n_d    = nrem_q[BIT_W-1:0];
							sel_widx_d = ev_q;
						end else begin
							nrem_d = nrem_q - COUNT_W'(scan_cnt);
							if (scan_last) begin
								state_d    = bmset_pkg::ST_IDLE;
								fin        = 1'b1;
								fin_status = bmset_pkg::STAT_NONE;
							end
						end
					end else begin
						if (scan_word != '0) begin
							state_d    = bmset_pkg::ST_IDLE;
							cur_rank_d = rank_inc;
							cur_pos_d  = CPOS_W'({ev_q, scan_bit});
							fin        = 1'b1;
							fin_status = bmset_pkg::STAT_OK;
							fin_found  = ENTRY_W'({ev_q, scan_bit});
						end else if (scan_last) begin
							// set changed under the cursor
							state_d    = bmset_pkg::ST_IDLE;
							cur_rank_d = '1;
							cur_pos_d  = '1;
							fin        = 1'b1;
							fin_status = bmset_pkg::STAT_NONE;
						end
					end
				end
			end

			bmset_pkg::ST_SELECT: begin
				// drop lowest set bits until the wanted one is lowest
				if (sel_n_q == '0) begin
					state_d    = bmset_pkg::ST_IDLE;
					cur_rank_d = COUNT_W'(req_n_q);
					cur_pos_d  = CPOS_W'({sel_widx_q, sel_bit});
					fin        = 1'b1;
					fin_status = bmset_pkg::STAT_OK;
					fin_found  = ENTRY_W'({sel_widx_q, sel_bit});
				end else begin
					sel_word_d = sel_word_q & (sel_word_q - 1'b1);
					sel_n_d    = sel_n_q - 1'b1;
				end
			end

			default: begin
				state_d = bmset_pkg::ST_IDLE;
			end
		endcase
	end

	// output register: free by construction whenever fin fires
	always_comb begin
		m_tvalid_d = m_tvalid_q;
		m_status_d = m_status_q;
		m_found_d  = m_found_q;
		m_count_d  = m_count_q;
		if (fin) begin
			m_tvalid_d = 1'b1;
			m_status_d = fin_status;
			m_found_d  = fin_found;
			m_count_d  = member_total_d;
		end else if (m_tready) begin
			m_tvalid_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= bmset_pkg::ST_CLEAR;
			clr_q          <= '0;
			dvalid_q       <= 1'b0;
			member_total_q <= '0;
			cur_rank_q     <= '1;
			cur_pos_q      <= '1;
			m_tvalid_q     <= 1'b0;
		end else begin
			state_q        <= state_d;
			clr_q          <= clr_d;
			dvalid_q       <= dvalid_d;
			member_total_q <= member_total_d;
			cur_rank_q     <= cur_rank_d;
			cur_pos_q      <= cur_pos_d;
			m_tvalid_q     <= m_tvalid_d;
		end
	end

	always_ff @(posedge clk) begin
		iss_q      <= iss_d;
		ev_q       <= ev_d;
		first_q    <= first_d;
		mode_nth_q <= mode_nth_d;
		shift_q    <= shift_d;
		nrem_q     <= nrem_d;
		req_n_q    <= req_n_d;
		sel_word_q <= sel_word_d;
		sel_n_q    <= sel_n_d;
		sel_widx_q <= sel_widx_d;
		mod_op_q   <= mod_op_d;
		mod_addr_q <= mod_addr_d;
		mod_bit_q  <= mod_bit_d;
		m_status_q <= m_status_d;
		m_found_q  <= m_found_d;
		m_count_q  <= m_count_d;
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_status_q;
	assign m_tdata  = {(bmset_pkg::M_TDATA_W - COUNT_W - ENTRY_W)'(0), m_count_q, m_found_q};

	// ----------------------------------------------------------- assertions
	`BMSET_ASSERT_NEVER(a_no_accept_in_clear, (state_q == bmset_pkg::ST_CLEAR) && s_tready, "accept during clearing pass")
	`BMSET_ASSERT_IMPL(a_total_from_modify, member_total_q != $past(member_total_q), $past(state_q) == bmset_pkg::ST_MODIFY, "member count changed outside modify")
	`BMSET_ASSERT_IMPL(a_found_only_ok, m_tvalid && (m_tuser != bmset_pkg::STAT_OK), m_tdata[15:0] == '0, "found entry set without found status")

endmodule
